/* rtl/suc_pkg.sv */
// Shared types, constants and helpers for the stereo utility channel processor.
`timescale 1ns / 1ps
package suc_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 14;
  localparam int FLAG_W      = 3;
  localparam int DELAY_W     = 18;
  localparam int DELAY_FRAC  = 8;
  localparam int DELAY_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SAT_IN_W    = 48;

  // option flag bit positions
  localparam int FLAG_INV_L = 0;
  localparam int FLAG_INV_R = 1;
  localparam int FLAG_MS    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASTER_GAIN  = 3'd0,
    REG_LEFT_GAIN    = 3'd1,
    REG_RIGHT_GAIN   = 3'd2,
    REG_MID_GAIN     = 3'd3,
    REG_SIDE_GAIN    = 3'd4,
    REG_OPTION_FLAGS = 3'd5,
    REG_DELAY_AMOUNT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_main;
    logic [GAIN_W-1:0]  gain_l;
    logic [GAIN_W-1:0]  gain_r;
    logic [GAIN_W-1:0]  gain_m;
    logic [GAIN_W-1:0]  gain_s;
    logic [FLAG_W-1:0]  option_flags;
    logic [DELAY_W-1:0] delay_amount;
  } cfg_t;

  // one stereo item between front and back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    logic                       clip;
  } pair_t;

  typedef struct packed {
    logic                       hit;
    logic signed [SAMPLE_W-1:0] val;
  } sat_t;

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'((64'sd1 <<< (SAMPLE_W-1)) - 1);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);

  function automatic sat_t saturate(input logic signed [SAT_IN_W-1:0] v);
    sat_t s;
    if (v > SAT_HI) begin
      s.hit = 1'b1;
      s.val = SAMPLE_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      s.hit = 1'b1;
      s.val = SAMPLE_W'(SAT_LO);
    end else begin
      s.hit = 1'b0;
      s.val = SAMPLE_W'(v);
    end
    return s;
  endfunction

endpackage

/* rtl/suc_if.sv */
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
interface suc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [suc_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [suc_pkg::SAMPLE_W-1:0] right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface suc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [suc_pkg::SAMPLE_W-1:0] left_out;
  logic signed [suc_pkg::SAMPLE_W-1:0] right_out;
  logic                                clipped;
  modport source (output valid, left_out, right_out, clipped, input ready);
  modport sink   (input valid, left_out, right_out, clipped, output ready);
endinterface

interface suc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [suc_pkg::CFG_IDX_W-1:0]     index;
  logic [suc_pkg::CFG_DATA_W-1:0]    wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

/* rtl/suc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module suc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/suc_front.sv */
// Front end: accepts items and, with the mid/side flag set, applies the mid/side matrix.
`timescale 1ns / 1ps
module suc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  suc_pkg::cfg_t        cfg,
  suc_in_if.sink               in_ch,
  output logic                 push,
  output suc_pkg::pair_t       push_item,
  input  logic                 q_full
);

  typedef enum logic [2:0] {F_IDLE, F_MID, F_SIDE, F_REB, F_PUSH} fstate_t;

  fstate_t state_r;
  logic signed [suc_pkg::SAMPLE_W-1:0] l_r, r_r;
  logic signed [41:0] mp_r, sp_r;
  logic clip_r;

  logic signed [suc_pkg::SAMPLE_W:0] sum, dif, mul_a;
  logic [suc_pkg::GAIN_W-1:0] mul_g;
  logic signed [41:0] prod;
  logic signed [42:0] lm, rm;
  suc_pkg::sat_t ls, rs;

  assign sum   = {l_r[suc_pkg::SAMPLE_W-1], l_r} + {r_r[suc_pkg::SAMPLE_W-1], r_r};
  assign dif   = {r_r[suc_pkg::SAMPLE_W-1], r_r} - {l_r[suc_pkg::SAMPLE_W-1], l_r};
  assign mul_a = (state_r == F_MID) ? sum : dif;
  assign mul_g = (state_r == F_MID) ? cfg.gain_m : cfg.gain_s;
  assign prod  = mul_a * $signed({1'b0, mul_g});

  // rebuild with round half up over GAIN_FRAC+1 bits
  assign lm = ($signed({mp_r[41], mp_r}) - $signed({sp_r[41], sp_r})
               + (43'sd1 <<< suc_pkg::GAIN_FRAC)) >>> (suc_pkg::GAIN_FRAC + 1);
  assign rm = ($signed({mp_r[41], mp_r}) + $signed({sp_r[41], sp_r})
               + (43'sd1 <<< suc_pkg::GAIN_FRAC)) >>> (suc_pkg::GAIN_FRAC + 1);
  assign ls = suc_pkg::saturate(suc_pkg::SAT_IN_W'(lm));
  assign rs = suc_pkg::saturate(suc_pkg::SAT_IN_W'(rm));

  assign in_ch.ready = (state_r == F_IDLE);
  assign push        = (state_r == F_PUSH) && !q_full;
  assign push_item   = '{l: l_r, r: r_r, clip: clip_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            l_r    <= in_ch.left_sample;
            r_r    <= in_ch.right_sample;
            clip_r <= 1'b0;
            state_r <= cfg.option_flags[suc_pkg::FLAG_MS] ? F_MID : F_PUSH;
          end
        end
        F_MID: begin
          mp_r    <= prod;
          state_r <= F_SIDE;
        end
        F_SIDE: begin
          sp_r    <= prod;
          state_r <= F_REB;
        end
        F_REB: begin
          l_r     <= ls.val;
          r_r     <= rs.val;
          clip_r  <= ls.hit | rs.hit;
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/suc_queue.sv */
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module suc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  suc_pkg::pair_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output suc_pkg::pair_t q_item
);

  suc_pkg::pair_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/suc_back.sv */
// Back end: fractional delay on the right channel, gains, saturation, output register.
`timescale 1ns / 1ps
module suc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  suc_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  suc_pkg::pair_t q_item,
  output logic           pop,
  suc_out_if.source      out_ch
);

  localparam int AW = suc_pkg::ADDR_W;
  localparam int SW = suc_pkg::SAMPLE_W;
  localparam int CGW = suc_pkg::GAIN_W + suc_pkg::GAIN_W - suc_pkg::GAIN_FRAC;

  typedef enum logic [3:0] {
    B_IDLE, B_T0, B_T1, B_INT, B_CGL, B_CGR, B_ML, B_MR, B_OUT
  } bstate_t;

  bstate_t state_r;
  logic [AW-1:0] wp_r;
  logic          full_r;
  logic signed [SW-1:0] l_r;
  logic signed [SW:0]   r_r, t0_r, t1_r;
  logic                 clip_r;
  logic                 byp_r, vld_r;
  logic [CGW-1:0]       cgl_r, cgr_r;
  logic signed [SW-1:0] lo_r;
  logic                 out_valid_r;
  logic signed [SW-1:0] out_l_r, out_r_r;
  logic                 out_c_r;

  logic                 delay_on;
  logic [AW-1:0]        dint, idx0, idx1, raddr;
  logic [suc_pkg::DELAY_FRAC-1:0] frac;
  logic [SW-1:0]        rdata;
  logic                 ram_we;
  logic                 byp0, vld0, byp1, vld1;
  logic signed [SW:0]   tap_val, dt;
  logic signed [SW+suc_pkg::DELAY_FRAC+1:0] iprod;
  logic signed [SW:0]   rint;
  logic [2*suc_pkg::GAIN_W-1:0] gprod;
  logic [CGW-1:0]       cg;
  logic signed [SW:0]   xs;
  logic signed [SW+CGW+1:0] sprod, sres;
  suc_pkg::sat_t        gs;
  logic                 out_free;

  assign delay_on = (cfg.delay_amount != '0);
  assign dint     = cfg.delay_amount[suc_pkg::DELAY_FRAC +: AW];
  assign frac     = cfg.delay_amount[suc_pkg::DELAY_FRAC-1:0];
  assign idx0     = wp_r - dint;
  assign idx1     = wp_r - dint - AW'(1);
  // ring entries not yet written since reset read as zero
  assign byp0     = (idx0 == wp_r);
  assign vld0     = full_r || (idx0 < wp_r);
  assign byp1     = (idx1 == wp_r);
  assign vld1     = full_r || (idx1 < wp_r);

  assign pop    = (state_r == B_IDLE) && q_valid;
  assign ram_we = pop && delay_on;
  assign raddr  = (state_r == B_IDLE) ? idx0 : idx1;

  suc_ram #(.WIDTH(SW), .DEPTH(suc_pkg::DELAY_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (q_item.r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign tap_val = byp_r ? r_r : (vld_r ? $signed({rdata[SW-1], rdata}) : '0);
  assign dt      = t1_r - t0_r;
  assign iprod   = $signed({1'b0, frac}) * dt;
  assign rint    = t0_r + (SW+1)'((iprod + (1 <<< (suc_pkg::DELAY_FRAC-1)))
                                  >>> suc_pkg::DELAY_FRAC);

  assign gprod = ((state_r == B_CGL) ? cfg.gain_l : cfg.gain_r) * cfg.gain_main;
  assign cg    = CGW'((gprod + (1 << (suc_pkg::GAIN_FRAC-1))) >> suc_pkg::GAIN_FRAC);

  always_comb begin
    if (state_r == B_ML) begin
      xs = cfg.option_flags[suc_pkg::FLAG_INV_L] ? -$signed({l_r[SW-1], l_r})
                                                  : $signed({l_r[SW-1], l_r});
    end else begin
      xs = cfg.option_flags[suc_pkg::FLAG_INV_R] ? -r_r : r_r;
    end
  end
  assign sprod = xs * $signed({1'b0, (state_r == B_ML) ? cgl_r : cgr_r});
  assign sres  = (sprod + (1 <<< (suc_pkg::GAIN_FRAC-1))) >>> suc_pkg::GAIN_FRAC;
  assign gs    = suc_pkg::saturate(suc_pkg::SAT_IN_W'(sres));

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wp_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != B_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            l_r    <= q_item.l;
            r_r    <= $signed({q_item.r[SW-1], q_item.r});
            clip_r <= q_item.clip;
            byp_r  <= byp0;
            vld_r  <= vld0;
            state_r <= delay_on ? B_T0 : B_CGL;
          end
        end
        B_T0: begin
          t0_r    <= tap_val;
          byp_r   <= byp1;
          vld_r   <= vld1;
          state_r <= B_T1;
        end
        B_T1: begin
          t1_r    <= tap_val;
          state_r <= B_INT;
        end
        B_INT: begin
          r_r     <= rint;
          wp_r    <= wp_r + AW'(1);
          full_r  <= full_r || (wp_r == AW'(suc_pkg::DELAY_DEPTH - 1));
          state_r <= B_CGL;
        end
        B_CGL: begin
          cgl_r   <= cg;
          state_r <= B_CGR;
        end
        B_CGR: begin
          cgr_r   <= cg;
          state_r <= B_ML;
        end
        B_ML: begin
          lo_r    <= gs.val;
          clip_r  <= clip_r | gs.hit;
          state_r <= B_MR;
        end
        B_MR: begin
          r_r     <= $signed({gs.val[SW-1], gs.val});
          clip_r  <= clip_r | gs.hit;
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            out_l_r     <= lo_r;
            out_r_r     <= SW'(r_r);
            out_c_r     <= clip_r;
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_l_r;
  assign out_ch.right_out = out_r_r;
  assign out_ch.clipped   = out_c_r;

  // ring pointer moves only in the interpolation step of a delayed item
  a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_INT) |=> $stable(wp_r))
    else $error("write position moved outside interpolation step");

  // once wrapped, every ring entry stays written
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("ring full flag dropped");

  // a finished item always lands in the output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && out_free) |=> (out_valid_r && state_r == B_IDLE))
    else $error("result not loaded into output register");

  // the ring is written only when an item is taken with the delay active
  a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == B_IDLE && q_valid && delay_on))
    else $error("delay ring written out of sequence");

endmodule

/* rtl/stereo_utility_channel_processor.sv */
// Top level of the stereo utility channel processor.
`timescale 1ns / 1ps
//  channel   port     dir   payload                          accepted when
//  input     in_ch    sink  left_sample, right_sample        valid & ready
//  result    out_ch   src   left_out, right_out, clipped     valid & ready
//  config    cfg_ch   sink  index (3b), wdata (32b)          valid & ready (ready always 1)
//
// Front end takes one item at a time: accept, then hand-off to the queue; mid/side adds
// two matrix multiplies and a rebuild step before the hand-off.
// Back end takes one item at a time through gains and output; the delay adds two reads
// of the single-read delay ring plus the interpolation step; it sets the sustained rate.
// A two-entry queue and the output register let front and back stall independently.
// Reset (rst_n, synchronous, active low) clears control state and ring pointers; unwritten
// ring entries read as zero via a fill mark, so no clearing pass is needed.
module stereo_utility_channel_processor (
  input logic       clk,
  input logic       rst_n,
  suc_in_if.sink    in_ch,
  suc_out_if.source out_ch,
  suc_cfg_if.sink   cfg_ch
);

  suc_pkg::cfg_t  cfg_r;
  logic           push, q_full, q_valid, pop;
  suc_pkg::pair_t push_item, q_item;

  // configuration registers; writes are expected only while the block is idle
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_main    <= suc_pkg::GAIN_W'(16384);
      cfg_r.gain_l       <= suc_pkg::GAIN_W'(16384);
      cfg_r.gain_r       <= suc_pkg::GAIN_W'(16384);
      cfg_r.gain_m       <= suc_pkg::GAIN_W'(16384);
      cfg_r.gain_s       <= suc_pkg::GAIN_W'(16384);
      cfg_r.option_flags <= '0;
      cfg_r.delay_amount <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        suc_pkg::REG_MASTER_GAIN:  cfg_r.gain_main    <= cfg_ch.wdata[suc_pkg::GAIN_W-1:0];
        suc_pkg::REG_LEFT_GAIN:    cfg_r.gain_l       <= cfg_ch.wdata[suc_pkg::GAIN_W-1:0];
        suc_pkg::REG_RIGHT_GAIN:   cfg_r.gain_r       <= cfg_ch.wdata[suc_pkg::GAIN_W-1:0];
        suc_pkg::REG_MID_GAIN:     cfg_r.gain_m       <= cfg_ch.wdata[suc_pkg::GAIN_W-1:0];
        suc_pkg::REG_SIDE_GAIN:    cfg_r.gain_s       <= cfg_ch.wdata[suc_pkg::GAIN_W-1:0];
        suc_pkg::REG_OPTION_FLAGS: cfg_r.option_flags <= cfg_ch.wdata[suc_pkg::FLAG_W-1:0];
        suc_pkg::REG_DELAY_AMOUNT: cfg_r.delay_amount <= cfg_ch.wdata[suc_pkg::DELAY_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // front: accept and mid/side
  suc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  suc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // back: delay ring, gains, saturation, result register
  suc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* bench/suc_tb_pkg.sv */
// Shared bench types: one expected result item.
`timescale 1ns / 1ps
package suc_tb_pkg;

  typedef struct packed {
    logic signed [suc_pkg::SAMPLE_W-1:0] left_out;
    logic signed [suc_pkg::SAMPLE_W-1:0] right_out;
    logic                                clipped;
  } stereo_result_t;
endpackage

/* bench/suc_checker.sv */
// Checker: watches the channels, predicts each processed pair and compares.
`timescale 1ns / 1ps
module suc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [suc_pkg::SAMPLE_W-1:0]   in_left,
  input  logic [suc_pkg::SAMPLE_W-1:0]   in_right,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [suc_pkg::SAMPLE_W-1:0]   out_left,
  input  logic [suc_pkg::SAMPLE_W-1:0]   out_right,
  input  logic                           out_clipped,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [suc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [suc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             error_count,
  output int                             pending_count
);

  logic [suc_pkg::GAIN_W-1:0]  g_master, g_left, g_right, g_mid, g_side;
  logic [suc_pkg::FLAG_W-1:0]  flags;
  logic [suc_pkg::DELAY_W-1:0] delay_q;
  longint                      ring [suc_pkg::DELAY_DEPTH];
  int unsigned                 wr_pos;
  suc_tb_pkg::stereo_result_t  pending_pairs [$];

  // round half up, floor shift (>>> on longint is arithmetic)
  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp24(longint v, inout bit hit);
    longint hi, lo;
    hi = (64'sd1 <<< (suc_pkg::SAMPLE_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1;
      return hi;
    end
    if (v < lo) begin
      hit = 1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint scale_by(longint x, logic [suc_pkg::GAIN_W-1:0] ch);
    longint comb;
    comb = rnd_shift(longint'(ch) * longint'(g_master), suc_pkg::GAIN_FRAC);
    return rnd_shift(x * comb, suc_pkg::GAIN_FRAC);
  endfunction

  function automatic suc_tb_pkg::stereo_result_t process_pair(
      logic signed [suc_pkg::SAMPLE_W-1:0] li, logic signed [suc_pkg::SAMPLE_W-1:0] ri);
    suc_tb_pkg::stereo_result_t res;
    bit hit;
    longint l, r, mp, sp, t0, t1, fr;
    int unsigned d;
    hit = 0;
    l = li;
    r = ri;
    if (flags[suc_pkg::FLAG_MS]) begin
      mp = (l + r) * longint'(g_mid);
      sp = (r - l) * longint'(g_side);
      l = clamp24(rnd_shift(mp - sp, suc_pkg::GAIN_FRAC + 1), hit);
      r = clamp24(rnd_shift(mp + sp, suc_pkg::GAIN_FRAC + 1), hit);
    end
    if (delay_q != 0) begin
      d = delay_q >> suc_pkg::DELAY_FRAC;
      fr = delay_q[suc_pkg::DELAY_FRAC-1:0];
      ring[wr_pos] = r;
      t0 = ring[(wr_pos + suc_pkg::DELAY_DEPTH - (d % suc_pkg::DELAY_DEPTH))
                % suc_pkg::DELAY_DEPTH];
      t1 = ring[(wr_pos + suc_pkg::DELAY_DEPTH - ((d + 1) % suc_pkg::DELAY_DEPTH))
                % suc_pkg::DELAY_DEPTH];
      r = t0 + rnd_shift(fr * (t1 - t0), suc_pkg::DELAY_FRAC);
      wr_pos = (wr_pos + 1) % suc_pkg::DELAY_DEPTH;
    end
    if (flags[suc_pkg::FLAG_INV_L]) l = -l;
    if (flags[suc_pkg::FLAG_INV_R]) r = -r;
    l = clamp24(scale_by(l, g_left), hit);
    r = clamp24(scale_by(r, g_right), hit);
    res.left_out  = l[suc_pkg::SAMPLE_W-1:0];
    res.right_out = r[suc_pkg::SAMPLE_W-1:0];
    res.clipped   = hit;
    return res;
  endfunction

  always @(posedge clk) begin
    suc_tb_pkg::stereo_result_t want;
    if (!rst_n) begin
      g_master <= suc_pkg::GAIN_W'(16384); g_left <= suc_pkg::GAIN_W'(16384);
      g_right <= suc_pkg::GAIN_W'(16384);
      g_mid <= suc_pkg::GAIN_W'(16384); g_side <= suc_pkg::GAIN_W'(16384);
      flags <= '0;
      delay_q <= '0;
      wr_pos = 0;
      foreach (ring[i]) ring[i] = 0;
      pending_pairs.delete();
      error_count <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && in_ready) pending_pairs.push_back(process_pair(in_left, in_right));
      if (out_valid && out_ready) begin
        if (pending_pairs.size() == 0) begin
          $display("%0t: unexpected result L=%0d R=%0d clip=%0b", $time,
                   $signed(out_left), $signed(out_right), out_clipped);
          error_count <= error_count + 1;
        end else begin
          want = pending_pairs.pop_front();
          if (want.left_out !== out_left || want.right_out !== out_right ||
              want.clipped !== out_clipped) begin
            $display("%0t: mismatch expected L=%0d R=%0d clip=%0b actual L=%0d R=%0d clip=%0b",
                     $time, want.left_out, want.right_out, want.clipped,
                     $signed(out_left), $signed(out_right), out_clipped);
            error_count <= error_count + 1;
          end
        end
      end
      pending_count <= pending_pairs.size();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          suc_pkg::REG_MASTER_GAIN:  g_master <= cfg_wdata[suc_pkg::GAIN_W-1:0];
          suc_pkg::REG_LEFT_GAIN:    g_left   <= cfg_wdata[suc_pkg::GAIN_W-1:0];
          suc_pkg::REG_RIGHT_GAIN:   g_right  <= cfg_wdata[suc_pkg::GAIN_W-1:0];
          suc_pkg::REG_MID_GAIN:     g_mid    <= cfg_wdata[suc_pkg::GAIN_W-1:0];
          suc_pkg::REG_SIDE_GAIN:    g_side   <= cfg_wdata[suc_pkg::GAIN_W-1:0];
          suc_pkg::REG_OPTION_FLAGS: flags    <= cfg_wdata[suc_pkg::FLAG_W-1:0];
          suc_pkg::REG_DELAY_AMOUNT: delay_q  <= cfg_wdata[suc_pkg::DELAY_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* bench/tb_stereo_utility_channel_processor.sv */
// Testbench top: clock, reset, stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps
module tb_stereo_utility_channel_processor;

  localparam int FS_POS    = 8388607;
  localparam int FS_NEG    = -8388608;
  localparam int GAIN_MAX  = 51811;
  localparam int CYCLE_CAP = 600000;

  logic clk = 0;
  logic rst_n = 0;
  int   error_count, pending_count;
  int   cycle_count = 0;
  bit   hold_long = 0;       // requests one long output stall

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  suc_in_if  in_ch ();
  suc_out_if out_ch ();
  suc_cfg_if cfg_ch ();

  stereo_utility_channel_processor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  suc_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_left(in_ch.left_sample), .in_right(in_ch.right_sample),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_left(out_ch.left_out), .out_right(out_ch.right_out),
    .out_clipped(out_ch.clipped),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready),
    .cfg_index(cfg_ch.index), .cfg_wdata(cfg_ch.wdata),
    .error_count(error_count), .pending_count(pending_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_pair(int l, int r, int no_gap);
    int g;
    g = (no_gap != 0) ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= suc_pkg::SAMPLE_W'(l);
    in_ch.right_sample <= suc_pkg::SAMPLE_W'(r);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_in();
    in_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(suc_pkg::reg_idx_t idx, logic [suc_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // idle point: every accepted item has come back out, then some slack
  task automatic drain();
    idle_in();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [suc_pkg::GAIN_W-1:0] pick_gain();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return suc_pkg::GAIN_W'(GAIN_MAX);
    if (p == 2) return 16'hFFFF;   // top bits past nominal range
    return suc_pkg::GAIN_W'($urandom_range(0, GAIN_MAX));
  endfunction

  // delay amounts: mostly zero or short, some at the ring end, the rest anywhere in range
  function automatic logic [suc_pkg::DELAY_W-1:0] pick_delay();
    int p;
    p = $urandom_range(0, 9);
    if (p < 2) return '0;
    if (p < 6) return suc_pkg::DELAY_W'($urandom_range(1, 16 * 256));
    if (p == 6) return {10'd1023, 8'($urandom_range(0, 255))};
    if (p == 7) return 18'h3FFFF;
    return suc_pkg::DELAY_W'($urandom_range(1, 261887));
  endfunction

  function automatic logic signed [suc_pkg::SAMPLE_W-1:0] pick_sample();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return suc_pkg::SAMPLE_W'(FS_POS);
    if (p == 1) return suc_pkg::SAMPLE_W'(FS_NEG);
    if (p == 2) return suc_pkg::SAMPLE_W'($urandom_range(0, 31) - 16);
    return suc_pkg::SAMPLE_W'($urandom());
  endfunction

  task automatic random_settings(bit extreme);
    write_reg(suc_pkg::REG_MASTER_GAIN, extreme ? GAIN_MAX : pick_gain());
    write_reg(suc_pkg::REG_LEFT_GAIN, extreme ? GAIN_MAX : pick_gain());
    write_reg(suc_pkg::REG_RIGHT_GAIN, extreme ? GAIN_MAX : pick_gain());
    write_reg(suc_pkg::REG_MID_GAIN, extreme ? GAIN_MAX : pick_gain());
    write_reg(suc_pkg::REG_SIDE_GAIN, extreme ? GAIN_MAX : pick_gain());
    write_reg(suc_pkg::REG_OPTION_FLAGS, $urandom());   // upper bits ignored
    write_reg(suc_pkg::REG_DELAY_AMOUNT,
              extreme ? 18'h3FFFF
                      : {$urandom_range(0, 1) ? 14'h0 : 14'h3FFF, 18'(pick_delay())});
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.left_sample  <= '0;
    in_ch.right_sample <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= suc_pkg::REG_MASTER_GAIN;
    cfg_ch.wdata       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, field extremes
    send_pair(FS_POS, FS_NEG, 0);
    send_pair(FS_NEG, FS_POS, 0);
    send_pair(0, 0, 0);
    send_pair(-1, 1, 0);
    drain();
    // full scale inverted on both sides, then mid/side overflow at max mid and side gains
    write_reg(suc_pkg::REG_OPTION_FLAGS, 3);
    send_pair(FS_NEG, FS_NEG, 0);
    send_pair(FS_POS, FS_POS, 0);
    drain();
    write_reg(suc_pkg::REG_OPTION_FLAGS, 4);
    write_reg(suc_pkg::REG_MID_GAIN, GAIN_MAX);
    write_reg(suc_pkg::REG_SIDE_GAIN, GAIN_MAX);
    send_pair(FS_POS, FS_POS, 0);
    send_pair(FS_POS, FS_NEG, 0);
    send_pair(FS_NEG, FS_POS, 0);
    drain();
    // zero delay with only fraction, then a whole-and-half tap and ring-end taps
    write_reg(suc_pkg::REG_OPTION_FLAGS, 0);
    write_reg(suc_pkg::REG_DELAY_AMOUNT, 1);
    send_pair(100, 1000, 0);
    send_pair(100, -1000, 0);
    drain();
    write_reg(suc_pkg::REG_DELAY_AMOUNT, 2 * 256 + 128);
    for (int i = 0; i < 5; i++) send_pair(i, (i + 1) * 4096, 0);
    drain();
    write_reg(suc_pkg::REG_DELAY_AMOUNT, 1023 * 256);
    send_pair(5, 77777, 0);
    send_pair(6, -77777, 0);
    drain();
    write_reg(suc_pkg::REG_DELAY_AMOUNT, 18'h3FFFF);
    write_reg(suc_pkg::REG_MASTER_GAIN, GAIN_MAX);
    write_reg(suc_pkg::REG_LEFT_GAIN, 0);
    write_reg(suc_pkg::REG_RIGHT_GAIN, GAIN_MAX);
    write_reg(suc_pkg::REG_OPTION_FLAGS, 7);
    send_pair(FS_NEG, FS_POS, 0);
    send_pair(FS_POS, FS_NEG, 0);
    drain();

    // Pressure: stall the output long while offering items back to back
    hold_long = 1;
    for (int i = 0; i < 20; i++) send_pair(pick_sample(), pick_sample(), 1);
    drain();

    // Random phases, first one at extreme settings
    for (int ph = 0; ph < 29; ph++) begin
      random_settings(ph == 0);
      for (int i = 0; i < 50; i++) send_pair(pick_sample(), pick_sample(), 0);
      drain();
    end
    // last phase: master gain, delay and flags at their register minimums
    write_reg(suc_pkg::REG_MASTER_GAIN, 0);
    write_reg(suc_pkg::REG_DELAY_AMOUNT, 0);
    write_reg(suc_pkg::REG_OPTION_FLAGS, 0);
    for (int i = 0; i < 10; i++) send_pair(pick_sample(), pick_sample(), 0);
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/suc_pkg.sv
rtl/suc_if.sv
rtl/suc_ram.sv
rtl/suc_front.sv
rtl/suc_queue.sv
rtl/suc_back.sv
rtl/stereo_utility_channel_processor.sv
bench/suc_tb_pkg.sv
bench/suc_checker.sv
bench/tb_stereo_utility_channel_processor.sv
